/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the filter RTL
// Simulation gets concurrent assertions; synthesis gets empty bodies.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OEF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("oef assertion failed");
`define OEF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("oef assertion failed");
`else
`define OEF_ASSERT(lbl, prop)
`define OEF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/oef_pkg.sv */
// ---------------------------------------------------------------------------
// oef_pkg
// Constants and shared types of the 3-D one euro filter.
// ---------------------------------------------------------------------------
package oef_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SAMPLE_W  = 32;
  localparam int REG_W     = 24;
  localparam int ALPHA_W   = FRAC_BITS + 1;
  localparam int DEN_W     = 36;
  localparam int NUMLO_W   = 32;
  localparam int CNT_W     = 6;

  // 2*pi in Q16
  localparam logic [18:0] TWO_PI_FX = 19'd411775;

  localparam logic [ALPHA_W-1:0] ONE_FX = ALPHA_W'(1) << FRAC_BITS;

  localparam logic [REG_W-1:0] MIN_CUTOFF_RST = 24'd58982;
  localparam logic [REG_W-1:0] SLOPE_RST      = 24'd459;
  localparam logic [REG_W-1:0] DCUT_RST       = 24'd65536;

  typedef enum logic [1:0] {
    REG_MIN_CUTOFF   = 2'd0,
    REG_CUTOFF_SLOPE = 2'd1,
    REG_DERIV_CUTOFF = 2'd2
  } reg_idx_t;

  // request to the serial divider
  typedef struct packed {
    logic               start;
    logic [DEN_W-1:0]   den;
    logic [DEN_W-1:0]   rem;
    logic [NUMLO_W-1:0] numlo;
    logic [CNT_W-1:0]   nbits;
  } div_req_t;

  // status from the serial divider
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [NUMLO_W-1:0] quo;
  } div_rsp_t;

endpackage

/* rtl/oef_mul.sv */
// ---------------------------------------------------------------------------
// oef_mul
// Shared multiplier: unsigned 33-bit by signed 34-bit, registered product.
// ---------------------------------------------------------------------------
module oef_mul (
  input  logic               clk,
  input  logic [32:0]        mul_a,
  input  logic signed [33:0] mul_b,
  output logic signed [67:0] prod
);

  logic signed [67:0] prod_r;

  // register the product for the next sequencer step
  always_ff @(posedge clk) begin
    prod_r <= 68'($signed({1'b0, mul_a}) * mul_b);
  end

  assign prod = prod_r;

endmodule

/* rtl/oef_div.sv */
// ---------------------------------------------------------------------------
// oef_div
// Restoring divider, one quotient bit per cycle, up to 32 bits.
// ---------------------------------------------------------------------------
module oef_div (
  input  logic             clk,
  input  logic             rst_n,
  input  oef_pkg::div_req_t req,
  output oef_pkg::div_rsp_t rsp
);

  logic [oef_pkg::DEN_W-1:0]   den_r;
  logic [oef_pkg::DEN_W-1:0]   rem_r;
  logic [oef_pkg::NUMLO_W-1:0] numlo_r;
  logic [oef_pkg::NUMLO_W-1:0] quo_r;
  logic [oef_pkg::CNT_W-1:0]   cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [oef_pkg::DEN_W:0]     trial;
  logic                        ge;
  logic [oef_pkg::DEN_W:0]     diff;

  // bring down the next numerator bit and try a subtract
  assign trial = {rem_r, numlo_r[oef_pkg::NUMLO_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == oef_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      den_r   <= req.den;
      rem_r   <= req.rem;
      numlo_r <= req.numlo;
      quo_r   <= '0;
    end else if (busy_r) begin
      rem_r   <= ge ? diff[oef_pkg::DEN_W-1:0] : trial[oef_pkg::DEN_W-1:0];
      numlo_r <= {numlo_r[oef_pkg::NUMLO_W-2:0], 1'b0};
      quo_r   <= {quo_r[oef_pkg::NUMLO_W-2:0], ge};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

/* rtl/one_euro_filter_3d_top.sv */
// ---------------------------------------------------------------------------
// one_euro_filter_3d_top
// Per-axis one euro filter on a 3-D Q16.16 sample, one shared multiplier
// and one serial divider driven by a small sequencer.
// ---------------------------------------------------------------------------
// channel  | dir | payload
// in_      | in  | tdata: sample_x, sample_y, sample_z, time_step
// out_     | out | tdata: smooth_x, smooth_y, smooth_z
// cfg_     | in  | cfg_index, cfg_data (24-bit register value)
//
// A filtered item runs one derivative alpha (three setup steps and a 17-step
// division) and then, per axis, a 32-step speed division (skipped when the
// speed saturates), four blend and cutoff steps, a position alpha and two
// update steps. Pass-through and first items go straight to the result
// register. Reset is synchronous, active low.
// The input is not ready while an item is at work or its result waits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module one_euro_filter_3d_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,   // sample_x, sample_y, sample_z, time_step
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // smooth_x, smooth_y, smooth_z
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_AM1, S_AM2, S_ADIV, S_AWAIT, S_SPD, S_SWAIT,
    S_EST, S_EST2, S_FC, S_FC2, S_Y, S_Y2
  } state_t;

  state_t state_r;

  logic [23:0] min_cutoff_r, slope_r, dcut_r;
  logic        first_r;
  logic        out_valid_r;
  logic [31:0] out_r [3];
  logic [31:0] s_r [3];
  logic [23:0] dt_r;
  logic [31:0] last_raw_r [3];
  logic [31:0] last_smooth_r [3];
  logic [31:0] last_est_r [3];
  logic [1:0]  axis_r;
  logic        alpha_sel_r;
  logic [oef_pkg::ALPHA_W-1:0] a_d_r, a_p_r;
  logic [31:0] spd_r, est_r;
  logic [23:0] fc_r;
  logic        neg_r;

  logic [32:0]        mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] prod;
  oef_pkg::div_req_t  div_req;
  oef_pkg::div_rsp_t  div_rsp;

  logic [23:0] fc_sel;
  logic [34:0] w_val;
  logic [35:0] d_val;
  logic [36:0] num_a;
  logic signed [32:0] spd_diff, est_diff, y_diff, raw_diff;
  logic [32:0] raw_mag;
  logic        raw_ovf;
  logic [31:0] est_mag;
  logic [31:0] spd_q;
  logic [40:0] fc_sum;
  logic [31:0] est_new, y_new;
  logic        in_acc;

  oef_mul u_mul (.clk(clk), .mul_a(mul_a), .mul_b(mul_b), .prod(prod));
  oef_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // floor((old << F) + prod) >> F
  function automatic logic [31:0] blend_fx(input logic [31:0] old_v,
                                           input logic signed [67:0] p);
    logic signed [50:0] acc;
    acc = $signed({{3{old_v[31]}}, old_v, 16'b0}) + $signed(p[50:0]);
    return acc[47:16];
  endfunction

  assign in_acc = in_tvalid && in_tready;

  // arithmetic around the shared units
  always_comb begin
    fc_sel   = alpha_sel_r ? fc_r : dcut_r;
    w_val    = prod[50:16];
    d_val    = {1'b0, w_val} + 36'd65536;
    num_a    = (37'd1 << 32) + {2'b0, d_val[35:1]};
    raw_diff = $signed({s_r[axis_r][31], s_r[axis_r]})
             - $signed({last_raw_r[axis_r][31], last_raw_r[axis_r]});
    raw_mag  = raw_diff[32] ? 33'(-raw_diff) : 33'(raw_diff);
    raw_ovf  = {7'b0, raw_mag[32:16]} >= dt_r;
    spd_diff = $signed({spd_r[31], spd_r})
             - $signed({last_est_r[axis_r][31], last_est_r[axis_r]});
    est_diff = spd_diff;
    y_diff   = $signed({s_r[axis_r][31], s_r[axis_r]})
             - $signed({last_smooth_r[axis_r][31], last_smooth_r[axis_r]});
    est_mag  = est_r[31] ? 32'(-est_r) : est_r;
    fc_sum   = {17'b0, min_cutoff_r} + {1'b0, prod[55:16]};
    est_new  = blend_fx(last_est_r[axis_r], prod);
    y_new    = blend_fx(last_smooth_r[axis_r], prod);
    if (neg_r) begin
      spd_q = (div_rsp.quo > 32'h8000_0000) ? 32'h8000_0000 : 32'(-div_rsp.quo);
    end else begin
      spd_q = div_rsp.quo[31] ? 32'h7FFF_FFFF : div_rsp.quo;
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_AM1: begin
        mul_a = {9'b0, fc_sel};
        mul_b = {10'b0, dt_r};
      end
      S_AM2: begin
        mul_a = {1'b0, prod[47:16]};
        mul_b = {15'b0, oef_pkg::TWO_PI_FX};
      end
      S_EST: begin
        mul_a = {16'b0, a_d_r};
        mul_b = {est_diff[32], est_diff};
      end
      S_FC: begin
        mul_a = {1'b0, est_mag};
        mul_b = {10'b0, slope_r};
      end
      S_Y: begin
        mul_a = {16'b0, a_p_r};
        mul_b = {y_diff[32], y_diff};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider requests
  always_comb begin
    div_req = '0;
    case (state_r)
      S_ADIV: begin
        div_req.start = 1'b1;
        div_req.den   = d_val;
        div_req.rem   = {16'b0, num_a[36:17]};
        div_req.numlo = {num_a[16:0], 15'b0};
        div_req.nbits = 6'd17;
      end
      S_SPD: begin
        div_req.start = !raw_ovf;
        div_req.den   = {12'b0, dt_r};
        div_req.rem   = {19'b0, raw_mag[32:16]};
        div_req.numlo = {raw_mag[15:0], 16'b0};
        div_req.nbits = 6'd32;
      end
      default: div_req = '0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_cutoff_r <= oef_pkg::MIN_CUTOFF_RST;
      slope_r      <= oef_pkg::SLOPE_RST;
      dcut_r       <= oef_pkg::DCUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        oef_pkg::REG_MIN_CUTOFF:   min_cutoff_r <= cfg_data;
        oef_pkg::REG_CUTOFF_SLOPE: slope_r      <= cfg_data;
        oef_pkg::REG_DERIV_CUTOFF: dcut_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, filter state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
      axis_r      <= '0;
      alpha_sel_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            for (int i = 0; i < 3; i++) begin
              s_r[i] <= in_tdata[32*i +: 32];
            end
            dt_r <= in_tdata[119:96];
            if (in_tdata[119:96] == 24'd0) begin
              for (int i = 0; i < 3; i++) begin
                out_r[i] <= in_tdata[32*i +: 32];
              end
              out_valid_r <= 1'b1;
            end else if (first_r) begin
              for (int i = 0; i < 3; i++) begin
                out_r[i]         <= in_tdata[32*i +: 32];
                last_raw_r[i]    <= in_tdata[32*i +: 32];
                last_smooth_r[i] <= in_tdata[32*i +: 32];
                last_est_r[i]    <= '0;
              end
              first_r     <= 1'b0;
              out_valid_r <= 1'b1;
            end else begin
              axis_r      <= '0;
              alpha_sel_r <= 1'b0;
              state_r     <= S_AM1;
            end
          end
        end
        S_AM1:  state_r <= S_AM2;
        S_AM2:  state_r <= S_ADIV;
        S_ADIV: state_r <= S_AWAIT;
        S_AWAIT: begin
          if (div_rsp.done) begin
            if (alpha_sel_r) begin
              a_p_r   <= oef_pkg::ONE_FX - div_rsp.quo[oef_pkg::ALPHA_W-1:0];
              state_r <= S_Y;
            end else begin
              a_d_r   <= oef_pkg::ONE_FX - div_rsp.quo[oef_pkg::ALPHA_W-1:0];
              state_r <= S_SPD;
            end
          end
        end
        S_SPD: begin
          neg_r <= raw_diff[32];
          if (raw_ovf) begin
            spd_r   <= raw_diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            state_r <= S_EST;
          end else begin
            state_r <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          if (div_rsp.done) begin
            spd_r   <= spd_q;
            state_r <= S_EST;
          end
        end
        S_EST:  state_r <= S_EST2;
        S_EST2: begin
          est_r   <= est_new;
          state_r <= S_FC;
        end
        S_FC:   state_r <= S_FC2;
        S_FC2: begin
          fc_r        <= (fc_sum > 41'hFF_FFFF) ? 24'hFF_FFFF : fc_sum[23:0];
          alpha_sel_r <= 1'b1;
          state_r     <= S_AM1;
        end
        S_Y:    state_r <= S_Y2;
        S_Y2: begin
          last_smooth_r[axis_r] <= y_new;
          last_est_r[axis_r]    <= est_r;
          last_raw_r[axis_r]    <= s_r[axis_r];
          out_r[axis_r]         <= y_new;
          alpha_sel_r           <= 1'b0;
          if (axis_r == 2'd2) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            axis_r  <= axis_r + 2'd1;
            state_r <= S_SPD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r[2], out_r[1], out_r[0]};
  assign cfg_ready  = 1'b1;

  `OEF_ASSERT(a_busy_not_ready, (state_r != S_IDLE) |-> !in_tready)
  `OEF_ASSERT(a_div_start_idle, div_req.start |-> !div_rsp.busy)
  `OEF_ASSERT(a_alpha_range, (state_r == S_SPD) |-> (a_d_r <= oef_pkg::ONE_FX))
  `OEF_ASSERT_NEXT(a_accept_moves, in_acc, out_valid_r || state_r == S_AM1)

endmodule
